@@ design/mtc_pkg.sv @@
// ============================================================================
// mtc_pkg
// Shared types and constants of the Markov transition counter.
// ============================================================================
`default_nettype none

package mtc_pkg;

    localparam int LEVELS_DEF     = 8;
    localparam int COUNT_BITS_DEF = 32;

    localparam int LVL_W   = 3;
    localparam int LC_W    = 4;
    localparam int VAL_W   = 31;
    localparam int CNT_W   = 32;
    localparam int SHARE_W = 20;
    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;

    localparam int NUM_REGS   = 8;
    localparam int NUM_BOUNDS = NUM_REGS - 1;

    localparam logic [LVL_W-1:0]   REG_LEVEL_COUNT = 3'd0;
    localparam logic [LC_W-1:0]    LEVEL_COUNT_RST = 4'd8;

    localparam logic               ACT_SAMPLE = 1'b0;
    localparam logic               ACT_READ   = 1'b1;

    localparam logic [SHARE_W-1:0] PPM_ONE        = 20'd1000000;
    localparam logic [2:0]         PPM_LAST_DIGIT = 3'd5;
    localparam logic [2:0]         DIV_SCALE_STEP = 3'd0;
    localparam logic [2:0]         DIV_LAST_STEP  = 3'd4;

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_SAMPLE_WR = 7'b0000010,
        ST_SUM       = 7'b0000100,
        ST_ADJ       = 7'b0001000,
        ST_LOAD      = 7'b0010000,
        ST_DIV       = 7'b0100000,
        ST_OUT       = 7'b1000000
    } t_state;

endpackage

`default_nettype wire

@@ design/mtc_if.sv @@
// ============================================================================
// mtc_if
// Valid/ready channels for input items and result items.
// ============================================================================
`default_nettype none

interface mtc_in_if;
    logic                      valid;
    logic                      ready;
    logic                      action;
    logic [mtc_pkg::VAL_W-1:0] sample_value;
    logic [mtc_pkg::LVL_W-1:0] row_select;

    modport source (output valid, action, sample_value, row_select, input ready);
    modport sink   (input valid, action, sample_value, row_select, output ready);
endinterface

interface mtc_out_if;
    logic                        valid;
    logic                        ready;
    logic [mtc_pkg::LVL_W-1:0]   level;
    logic [mtc_pkg::LVL_W-1:0]   column;
    logic [mtc_pkg::CNT_W-1:0]   count;
    logic [mtc_pkg::SHARE_W-1:0] share_ppm;
    logic                        last;

    modport source (output valid, level, column, count, share_ppm, last, input ready);
    modport sink   (input valid, level, column, count, share_ppm, last, output ready);
endinterface

`default_nettype wire

@@ design/mtc_ram.sv @@
// ============================================================================
// mtc_ram
// Simple dual-port RAM with one write port and one registered read port.
// ============================================================================
`default_nettype none

module mtc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ design/markov_transition_counter_top.sv @@
// ============================================================================
// markov_transition_counter_top
// Counts level-to-level transitions; a sample is read, then written back when
// the output register is free, which also registers its result. A readout
// totals the row by column, adjusts it, then per column loads the count, runs
// long division unless the share is known directly, and outputs the result.
// Reset restores the control and APB registers; valid bits clear all counts.
// ============================================================================
`default_nettype none

module markov_transition_counter_top #(
    parameter int LEVELS     = mtc_pkg::LEVELS_DEF,
    parameter int COUNT_BITS = mtc_pkg::COUNT_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    mtc_in_if.sink                           i_in,
    mtc_out_if.source                        o_out,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mtc_pkg::APB_AW-1:0]  paddr,
    input  wire logic [mtc_pkg::APB_DW-1:0]  pwdata,
    output logic      [mtc_pkg::APB_DW-1:0]  prdata,
    output logic                             pready
);

    localparam int DEPTH = LEVELS * LEVELS;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = COUNT_BITS + $clog2(LEVELS) + 1;
    localparam int RW    = TW + 4;
    localparam int LW    = mtc_pkg::LVL_W;
    localparam int SW    = mtc_pkg::SHARE_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [2:0] DIV_LAST_STEP_W = mtc_pkg::DIV_LAST_STEP;

    function automatic logic [AW-1:0] addr_of(input logic [LW-1:0] row,
                                              input logic [LW-1:0] col);
        return AW'(int'(row) * LEVELS + int'(col));
    endfunction

    // Configuration registers.
    logic [mtc_pkg::LC_W-1:0]  r_level_count;
    logic [mtc_pkg::VAL_W-1:0] r_bound [1:mtc_pkg::NUM_BOUNDS];
    logic [LW-1:0]             cfg_idx;
    logic                      cfg_wr;

    // Control state.
    mtc_pkg::t_state r_state, n_state;
    logic [LW-1:0]   r_prev, n_prev;
    logic            r_has_prev, n_has_prev;
    logic [DEPTH-1:0] r_vld, n_vld;
    logic            r_o_valid, n_o_valid;

    // Datapath registers.
    logic [LW-1:0]         r_lv, n_lv;
    logic [AW-1:0]         r_wr_addr, n_wr_addr;
    logic                  r_do_wr, n_do_wr;
    logic [LW-1:0]         r_row, n_row;
    logic [LW-1:0]         r_col, n_col;
    logic [TW-1:0]         r_total, n_total;
    logic [COUNT_BITS-1:0] r_diag, n_diag;
    logic                  r_adj_en, n_adj_en;
    logic [LW-1:0]         r_adj_col, n_adj_col;
    logic [TW-1:0]         r_run, n_run;
    logic [SW-1:0]         r_given, n_given;
    logic [TW-1:0]         r_val, n_val;
    logic [RW-1:0]         r_rem, n_rem;
    logic [SW-1:0]         r_q, n_q;
    logic [2:0]            r_digit, n_digit;
    logic [2:0]            r_step, n_step;
    logic [SW-1:0]         r_share, n_share;
    logic                  r_rd_vld;

    logic [LW-1:0]           r_o_level, n_o_level;
    logic [LW-1:0]           r_o_column, n_o_column;
    logic [mtc_pkg::CNT_W-1:0] r_o_count, n_o_count;
    logic [SW-1:0]           r_o_share, n_o_share;
    logic                    r_o_last, n_o_last;

    // Memory port.
    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [COUNT_BITS-1:0] ram_wdata, ram_rdata;

    // Combinational helpers.
    logic [mtc_pkg::LC_W-1:0] n_eff;
    logic [LW-1:0]            lv;
    logic                     in_fire, out_fire, can_load, last_col;
    logic [COUNT_BITS-1:0]    mem_val;
    logic [TW-1:0]            v_adj, run_sum;
    logic [RW-1:0]            sub_op;
    logic [1:0]               sub_sh;
    logic [SW-1:0]            q_next;
    logic [RW-1:0]            rem_next;

    mtc_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // APB register file.
    assign pready  = 1'b1;
    assign cfg_idx = paddr[mtc_pkg::APB_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        if (cfg_idx == mtc_pkg::REG_LEVEL_COUNT) begin
            prdata = mtc_pkg::APB_DW'(r_level_count);
        end else begin
            prdata = mtc_pkg::APB_DW'(r_bound[cfg_idx]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_count <= mtc_pkg::LEVEL_COUNT_RST;
            for (int k = 1; k <= mtc_pkg::NUM_BOUNDS; k++) begin
                r_bound[k] <= '0;
            end
        end else if (cfg_wr) begin
            if (cfg_idx == mtc_pkg::REG_LEVEL_COUNT) begin
                r_level_count <= pwdata[mtc_pkg::LC_W-1:0];
            end
            for (int k = 1; k <= mtc_pkg::NUM_BOUNDS; k++) begin
                if (cfg_idx == LW'(k)) begin
                    r_bound[k] <= pwdata[mtc_pkg::VAL_W-1:0];
                end
            end
        end
    end

    // Effective level count and sample classification.
    always_comb begin
        if (r_level_count == '0) begin
            n_eff = mtc_pkg::LC_W'(1);
        end else if (r_level_count > mtc_pkg::LC_W'(LEVELS)) begin
            n_eff = mtc_pkg::LC_W'(LEVELS);
        end else begin
            n_eff = r_level_count;
        end
    end

    always_comb begin
        lv = LW'(n_eff - mtc_pkg::LC_W'(1));
        for (int k = mtc_pkg::NUM_BOUNDS; k >= 1; k--) begin
            if ((mtc_pkg::LC_W'(k) < n_eff) && (i_in.sample_value < r_bound[k])) begin
                lv = LW'(k - 1);
            end
        end
    end

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = r_o_valid && o_out.ready;
    assign can_load = !r_o_valid || o_out.ready;
    assign last_col = ({1'b0, r_col} + mtc_pkg::LC_W'(1)) == n_eff;

    assign mem_val   = r_rd_vld ? ram_rdata : '0;
    assign v_adj     = TW'(mem_val) + TW'(r_adj_en && (r_col == r_adj_col));
    assign run_sum   = r_run + v_adj;
    assign ram_waddr = r_wr_addr;
    assign ram_wdata = (mem_val == COUNT_MAX) ? mem_val : mem_val + COUNT_BITS'(1);

    assign sub_sh = 2'(DIV_LAST_STEP_W - r_step);
    assign sub_op = RW'(r_total) << sub_sh;

    always_comb begin
        if (r_rem >= sub_op) begin
            rem_next = r_rem - sub_op;
            q_next   = r_q + (SW'(1) << sub_sh);
        end else begin
            rem_next = r_rem;
            q_next   = r_q;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_prev     = r_prev;
        n_has_prev = r_has_prev;
        n_vld      = r_vld;
        n_lv       = r_lv;
        n_wr_addr  = r_wr_addr;
        n_do_wr    = r_do_wr;
        n_row      = r_row;
        n_col      = r_col;
        n_total    = r_total;
        n_diag     = r_diag;
        n_adj_en   = r_adj_en;
        n_adj_col  = r_adj_col;
        n_run      = r_run;
        n_given    = r_given;
        n_val      = r_val;
        n_rem      = r_rem;
        n_q        = r_q;
        n_digit    = r_digit;
        n_step     = r_step;
        n_share    = r_share;
        n_o_level  = r_o_level;
        n_o_column = r_o_column;
        n_o_count  = r_o_count;
        n_o_share  = r_o_share;
        n_o_last   = r_o_last;
        n_o_valid  = out_fire ? 1'b0 : r_o_valid;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = '0;

        case (r_state)
            mtc_pkg::ST_IDLE: begin
                if (in_fire) begin
                    if (i_in.action == mtc_pkg::ACT_SAMPLE) begin
                        n_lv       = lv;
                        n_wr_addr  = addr_of(r_prev, lv);
                        n_do_wr    = r_has_prev;
                        ram_re     = r_has_prev;
                        ram_raddr  = addr_of(r_prev, lv);
                        n_prev     = lv;
                        n_has_prev = 1'b1;
                        n_state    = mtc_pkg::ST_SAMPLE_WR;
                    end else if ({1'b0, i_in.row_select} < n_eff) begin
                        n_row     = i_in.row_select;
                        n_col     = '0;
                        n_total   = '0;
                        ram_re    = 1'b1;
                        ram_raddr = addr_of(i_in.row_select, '0);
                        n_state   = mtc_pkg::ST_SUM;
                    end
                end
            end
            mtc_pkg::ST_SAMPLE_WR: begin
                if (can_load) begin
                    ram_we = r_do_wr;
                    if (r_do_wr) begin
                        n_vld[r_wr_addr] = 1'b1;
                    end
                    n_o_valid  = 1'b1;
                    n_o_level  = r_lv;
                    n_o_column = '0;
                    n_o_count  = '0;
                    n_o_share  = '0;
                    n_o_last   = 1'b1;
                    n_state    = mtc_pkg::ST_IDLE;
                end
            end
            mtc_pkg::ST_SUM: begin
                n_total = r_total + TW'(mem_val);
                if (r_col == r_row) begin
                    n_diag = mem_val;
                end
                if (last_col) begin
                    n_state = mtc_pkg::ST_ADJ;
                end else begin
                    n_col     = r_col + LW'(1);
                    ram_re    = 1'b1;
                    ram_raddr = addr_of(r_row, r_col + LW'(1));
                end
            end
            mtc_pkg::ST_ADJ: begin
                if (TW'(r_diag) == r_total) begin
                    n_adj_en = 1'b1;
                    n_total  = r_total + TW'(1);
                end else begin
                    n_adj_en = 1'b0;
                end
                n_adj_col = (r_row == '0) ? LW'(1) : r_row - LW'(1);
                n_col     = '0;
                n_run     = '0;
                n_given   = '0;
                ram_re    = 1'b1;
                ram_raddr = addr_of(r_row, '0);
                n_state   = mtc_pkg::ST_LOAD;
            end
            mtc_pkg::ST_LOAD: begin
                n_val = v_adj;
                n_run = run_sum;
                if (run_sum == r_total) begin
                    n_share = mtc_pkg::PPM_ONE - r_given;
                    n_state = mtc_pkg::ST_OUT;
                end else if (v_adj == '0) begin
                    n_share = '0;
                    n_state = mtc_pkg::ST_OUT;
                end else begin
                    n_rem   = RW'(v_adj);
                    n_q     = '0;
                    n_digit = '0;
                    n_step  = mtc_pkg::DIV_SCALE_STEP;
                    n_state = mtc_pkg::ST_DIV;
                end
            end
            mtc_pkg::ST_DIV: begin
                if (r_step == mtc_pkg::DIV_SCALE_STEP) begin
                    n_rem  = (r_rem << 3) + (r_rem << 1);
                    n_q    = (r_q << 3) + (r_q << 1);
                    n_step = r_step + 3'd1;
                end else begin
                    n_rem = rem_next;
                    n_q   = q_next;
                    if (r_step == mtc_pkg::DIV_LAST_STEP) begin
                        n_step = mtc_pkg::DIV_SCALE_STEP;
                        if (r_digit == mtc_pkg::PPM_LAST_DIGIT) begin
                            n_share = q_next;
                            n_given = r_given + q_next;
                            n_state = mtc_pkg::ST_OUT;
                        end else begin
                            n_digit = r_digit + 3'd1;
                        end
                    end else begin
                        n_step = r_step + 3'd1;
                    end
                end
            end
            mtc_pkg::ST_OUT: begin
                if (can_load) begin
                    n_o_valid  = 1'b1;
                    n_o_level  = r_row;
                    n_o_column = r_col;
                    n_o_count  = (64'(r_val) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(r_val);
                    n_o_share  = r_share;
                    n_o_last   = last_col;
                    if (last_col) begin
                        n_state = mtc_pkg::ST_IDLE;
                    end else begin
                        n_col     = r_col + LW'(1);
                        ram_re    = 1'b1;
                        ram_raddr = addr_of(r_row, r_col + LW'(1));
                        n_state   = mtc_pkg::ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = mtc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mtc_pkg::ST_IDLE;
            r_prev     <= '0;
            r_has_prev <= 1'b0;
            r_vld      <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_prev     <= n_prev;
            r_has_prev <= n_has_prev;
            r_vld      <= n_vld;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lv       <= n_lv;
        r_wr_addr  <= n_wr_addr;
        r_do_wr    <= n_do_wr;
        r_row      <= n_row;
        r_col      <= n_col;
        r_total    <= n_total;
        r_diag     <= n_diag;
        r_adj_en   <= n_adj_en;
        r_adj_col  <= n_adj_col;
        r_run      <= n_run;
        r_given    <= n_given;
        r_val      <= n_val;
        r_rem      <= n_rem;
        r_q        <= n_q;
        r_digit    <= n_digit;
        r_step     <= n_step;
        r_share    <= n_share;
        r_o_level  <= n_o_level;
        r_o_column <= n_o_column;
        r_o_count  <= n_o_count;
        r_o_share  <= n_o_share;
        r_o_last   <= n_o_last;
        if (ram_re) begin
            r_rd_vld <= r_vld[ram_raddr];
        end
    end

    assign i_in.ready      = (r_state == mtc_pkg::ST_IDLE);
    assign o_out.valid     = r_o_valid;
    assign o_out.level     = r_o_level;
    assign o_out.column    = r_o_column;
    assign o_out.count     = r_o_count;
    assign o_out.share_ppm = r_o_share;
    assign o_out.last      = r_o_last;

`ifndef SYNTHESIS
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("Count memory read and write in the same cycle.");

    a_sample_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (i_in.action == mtc_pkg::ACT_SAMPLE))
        |=> (r_state == mtc_pkg::ST_SAMPLE_WR))
        else $error("Sample transfer not followed by its write-back cycle.");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == mtc_pkg::ST_DIV) && (r_step == mtc_pkg::DIV_SCALE_STEP))
        |-> (r_rem < RW'(r_total)))
        else $error("Division remainder not below the row total.");

    a_quot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mtc_pkg::ST_DIV) |-> (r_q < mtc_pkg::PPM_ONE))
        else $error("Partial share exceeds one million.");

    a_share_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_share <= mtc_pkg::PPM_ONE))
        else $error("Result share exceeds one million.");
`endif

endmodule

`default_nettype wire
